@@ rtl/sat_axis_overlap_accumulator_defines.svh @@
// Assertion macros for the separating-axis overlap accumulator.
// Used by the checker file only; no dependencies.
`ifndef SAT_AXIS_OVERLAP_ACCUMULATOR_DEFINES_SVH
`define SAT_AXIS_OVERLAP_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAOA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("saoa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("saoa assertion failed");

`endif

@@ rtl/saoa_pkg.sv @@
// Shared types and constants of the separating-axis overlap accumulator.
// No dependencies.
package saoa_pkg;

	localparam int IN_W        = 160;
	localparam int OUT_W       = 64;
	localparam int INIT_W      = 31;
	localparam int AXIS_W      = 16;
	localparam int PROJ_W      = 32;
	localparam int DIST_W      = 32;
	localparam int QUEUE_DEPTH = 4;

	// 1000.0 in Q16.16
	localparam logic [INIT_W-1:0] INIT_DIST_RESET = 31'd65536000;

	// input tdata bit positions (low bit of each field)
	localparam int AX_LSB = 0;
	localparam int AY_LSB = 16;
	localparam int A1_LSB = 32;
	localparam int A2_LSB = 64;
	localparam int B1_LSB = 96;
	localparam int B2_LSB = 128;

	typedef enum logic [2:0] {
		CASE_NONE,
		CASE_CONT_A,
		CASE_CONT_B,
		CASE_A_FIRST,
		CASE_A_SECOND
	} ovl_case_t;

	// one classified axis, front to back
	typedef struct packed {
		logic                     hit;
		logic signed [DIST_W-1:0] push_dist;
		logic [AXIS_W-1:0]        ax;
		logic [AXIS_W-1:0]        ay;
		logic                     last;
	} item_t;

endpackage

@@ rtl/saoa_front.sv @@
// Front end: accepts axis beats, classifies interval overlap, derives the
// saturated push-out distance over two stages. Depends on saoa_pkg.
module saoa_front #(
	parameter int DEPTH = saoa_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [saoa_pkg::IN_W-1:0] in_data,
	input  logic                     in_last,
	input  logic                     pop,
	output logic                     push,
	output saoa_pkg::item_t          push_item
);

	localparam int CW = $clog2(DEPTH + 1);

	logic          [CW-1:0] occ_q;
	logic                   acc;
	logic signed [31:0]     a1, a2, b1, b2;
	logic                   in_a1, in_a2, in_b1, in_b2, cont_a, cont_b;
	logic signed [32:0]     e1, e2, d_b2a1, d_b1a2, d_a1b2, d_a2b1;
	logic signed [32:0]     c_lt, c_ge;
	saoa_pkg::ovl_case_t    cs;

	logic                   v_s1;
	saoa_pkg::ovl_case_t    case_s1;
	logic signed [32:0]     e1_s1, e2_s1, c_lt_s1, c_ge_s1;
	logic [15:0]            ax_s1, ay_s1;
	logic                   last_s1;

	logic [32:0]            m1, m2;
	logic signed [32:0]     pick;
	logic signed [31:0]     dsat;

	logic                   v_s2;
	saoa_pkg::item_t        item_s2;

	// credits: beats accepted but not yet taken from the queue
	assign acc      = in_valid & in_ready;
	assign in_ready = (occ_q != CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc && !pop) begin
			occ_q <= occ_q + CW'(1);
		end else if (!acc && pop) begin
			occ_q <= occ_q - CW'(1);
		end
	end

	assign a1 = in_data[saoa_pkg::A1_LSB +: 32];
	assign a2 = in_data[saoa_pkg::A2_LSB +: 32];
	assign b1 = in_data[saoa_pkg::B1_LSB +: 32];
	assign b2 = in_data[saoa_pkg::B2_LSB +: 32];

	// strict interior tests, either end order
	always_comb begin
		in_a1  = (b1 < a1 && a1 < b2) || (b2 < a1 && a1 < b1);
		in_a2  = (b1 < a2 && a2 < b2) || (b2 < a2 && a2 < b1);
		in_b1  = (a1 < b1 && b1 < a2) || (a2 < b1 && b1 < a1);
		in_b2  = (a1 < b2 && b2 < a2) || (a2 < b2 && b2 < a1);
		cont_a = (in_a1 || a1 == b1) && (in_a2 || a2 == b2);
		cont_b = (in_b1 || b1 == a1) && (in_b2 || b2 == a2);
		if (cont_a) begin
			cs = saoa_pkg::CASE_CONT_A;
		end else if (cont_b) begin
			cs = saoa_pkg::CASE_CONT_B;
		end else if (in_a1) begin
			cs = saoa_pkg::CASE_A_FIRST;
		end else if (in_a2) begin
			cs = saoa_pkg::CASE_A_SECOND;
		end else begin
			cs = saoa_pkg::CASE_NONE;
		end
	end

	assign e1     = 33'(a1) - 33'(b1);
	assign e2     = 33'(a2) - 33'(b2);
	assign d_b2a1 = 33'(b2) - 33'(a1);
	assign d_b1a2 = 33'(b1) - 33'(a2);
	assign d_a1b2 = 33'(a1) - 33'(b2);
	assign d_a2b1 = 33'(a2) - 33'(b1);

	// candidates for "first gap smaller" / otherwise
	always_comb begin
		case (cs)
			saoa_pkg::CASE_CONT_A: begin
				c_lt = d_b1a2;
				c_ge = d_b2a1;
			end
			saoa_pkg::CASE_CONT_B: begin
				c_lt = d_a1b2;
				c_ge = d_a2b1;
			end
			saoa_pkg::CASE_A_SECOND: begin
				c_lt = d_b1a2;
				c_ge = d_b1a2;
			end
			default: begin
				c_lt = d_b2a1;
				c_ge = d_b2a1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		case_s1 <= cs;
		e1_s1   <= e1;
		e2_s1   <= e2;
		c_lt_s1 <= c_lt;
		c_ge_s1 <= c_ge;
		ax_s1   <= in_data[saoa_pkg::AX_LSB +: 16];
		ay_s1   <= in_data[saoa_pkg::AY_LSB +: 16];
		last_s1 <= in_last;
	end

	// stage 2: gap magnitudes, pick, saturate to 32 bits
	always_comb begin
		m1   = e1_s1[32] ? 33'(-e1_s1) : 33'(e1_s1);
		m2   = e2_s1[32] ? 33'(-e2_s1) : 33'(e2_s1);
		pick = (m1 < m2) ? c_lt_s1 : c_ge_s1;
		if (pick[32] != pick[31]) begin
			dsat = pick[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			dsat = pick[31:0];
		end
	end

	always_ff @(posedge clk) begin
		item_s2.hit       <= (case_s1 != saoa_pkg::CASE_NONE);
		item_s2.push_dist <= dsat;
		item_s2.ax        <= ax_s1;
		item_s2.ay        <= ay_s1;
		item_s2.last      <= last_s1;
	end

	assign push      = v_s2;
	assign push_item = item_s2;

endmodule

@@ rtl/saoa_queue.sv @@
// Short FIFO of classified axes between front and back.
// Depends on saoa_pkg.
module saoa_queue #(
	parameter int DEPTH = saoa_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  saoa_pkg::item_t push_item,
	input  logic            pop,
	output logic            head_valid,
	output saoa_pkg::item_t head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	saoa_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	// never overfills: the front holds credits for every slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_q];

endmodule

@@ rtl/saoa_back.sv @@
// Back end: running minimum over a pair's axes, result register, config.
// Depends on saoa_pkg.
module saoa_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  saoa_pkg::item_t            head_item,
	output logic                       pop,
	input  logic                       cfg_valid,
	input  logic [saoa_pkg::INIT_W-1:0] cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [saoa_pkg::OUT_W-1:0] out_data,
	output logic                       out_user
);

	logic [saoa_pkg::INIT_W-1:0] init_q;
	logic                        still_q;
	logic signed [31:0]          best_q;
	logic [31:0]                 best_mag_q;
	logic [15:0]                 bax_q, bay_q;

	logic                        out_valid_q;
	logic [saoa_pkg::OUT_W-1:0]  out_data_q;
	logic                        out_user_q;

	logic                        can_emit, emit;
	logic [31:0]                 dmag;
	logic                        take;
	logic                        still_n;
	logic signed [31:0]          best_n;
	logic [31:0]                 best_mag_n;
	logic [15:0]                 bax_n, bay_n;

	assign can_emit = !out_valid_q || out_ready;
	assign pop      = head_valid && (!head_item.last || can_emit);
	assign emit     = pop && head_item.last;

	always_comb begin
		dmag       = head_item.push_dist[31] ? 32'(-head_item.push_dist)
			: 32'(head_item.push_dist);
		take       = still_q && head_item.hit && (dmag < best_mag_q);
		still_n    = still_q && head_item.hit;
		best_n     = take ? head_item.push_dist : best_q;
		best_mag_n = take ? dmag : best_mag_q;
		bax_n      = take ? head_item.ax : bax_q;
		bay_n      = take ? head_item.ay : bay_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= saoa_pkg::INIT_DIST_RESET;
			still_q    <= 1'b1;
			best_q     <= 32'(saoa_pkg::INIT_DIST_RESET);
			best_mag_q <= 32'(saoa_pkg::INIT_DIST_RESET);
			bax_q      <= '0;
			bay_q      <= '0;
		end else if (cfg_valid) begin
			init_q     <= cfg_data;
			still_q    <= 1'b1;
			best_q     <= 32'(cfg_data);
			best_mag_q <= 32'(cfg_data);
			bax_q      <= '0;
			bay_q      <= '0;
		end else if (emit) begin
			still_q    <= 1'b1;
			best_q     <= 32'(init_q);
			best_mag_q <= 32'(init_q);
			bax_q      <= '0;
			bay_q      <= '0;
		end else if (pop) begin
			still_q    <= still_n;
			best_q     <= best_n;
			best_mag_q <= best_mag_n;
			bax_q      <= bax_n;
			bay_q      <= bay_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// non-colliding pair reports all zeros
	always_ff @(posedge clk) begin
		if (emit) begin
			out_user_q <= still_n;
			out_data_q <= still_n ? {bay_n, bax_n, best_n} : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

@@ rtl/sat_axis_overlap_accumulator.sv @@
// Top level of the separating-axis overlap accumulator.
// Depends on saoa_pkg, saoa_front, saoa_queue, saoa_back.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------
//  s_axis   | in  | one separating axis with both projection intervals
//  m_axis   | out | one result per shape pair (colliding, min dist, axis)
//  cfg      | in  | initial_min_distance, Q16.16, 31 bits unsigned
//
// Cycles: one axis beat per clock, sustained while m_axis_tready stays high.
//   The result beat passes through two front stages (compare/subtract, then
//   magnitude pick and saturate), the queue write, and the back end's min
//   update into the output reg.
// Stalls: the queue decouples the halves; s_axis_tready drops only when
//   QUEUE_DEPTH beats are in flight between the front and the back.
// Reset: arst_n clears control state; initial_min_distance returns to 1000.0.
// A cfg write reloads the accumulator and drops any pair in progress.
module sat_axis_overlap_accumulator #(
	parameter int QUEUE_DEPTH = saoa_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// axis_x[15:0], axis_y[31:16], proj_a_first[63:32], proj_a_second[95:64],
	// proj_b_first[127:96], proj_b_second[159:128]
	input  logic [159:0] s_axis_tdata,
	input  logic         s_axis_tlast,   // last_axis
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// min_distance[31:0], min_axis_x[47:32], min_axis_y[63:48]
	output logic [63:0]  m_axis_tdata,
	output logic         m_axis_tuser,   // colliding
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [30:0]  cfg_data        // initial_min_distance
);

	logic            push, pop, head_valid;
	saoa_pkg::item_t push_item, head_item;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	saoa_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.pop      (pop),
		.push     (push),
		.push_item(push_item)
	);

	saoa_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	saoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

@@ rtl/saoa_checker.sv @@
// Port-level checks of the overlap accumulator, bound to the top level.
// Depends on sat_axis_overlap_accumulator_defines.svh.
`include "sat_axis_overlap_accumulator_defines.svh"

module saoa_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [159:0] s_axis_tdata,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic         m_axis_tuser,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [30:0]  cfg_data
);

	// a stalled result beat holds
	`SAOA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// separated pairs report zero distance and zero axis
	`SAOA_ASSERT_IMPL(a_sep_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 64'd0)

	// register writes never back-pressure
	`SAOA_ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind sat_axis_overlap_accumulator saoa_checker u_saoa_checker (.*);
